FILE: src/tdpt_pkg.sv
// Shared constants and controller/datapath interface types for the
// trial-division prime test. No dependencies.
package tdpt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(VALUE_WIDTH - 1);

    typedef struct packed {
        logic load;        // capture candidate, reset divisor to 3
        logic div_start;   // clear remainder, reload dividend
        logic div_step;    // one restoring division step
        logic next_div;    // advance divisor by 2
    } tdpt_cmd_t;

    typedef struct packed {
        logic below_two;   // negative, zero or one
        logic is_two;
        logic is_even;
        logic div_last;    // current step is the final one of a division
        logic d_gt_q;      // divisor exceeds quotient: search is over
        logic rem_zero;
    } tdpt_status_t;

endpackage

FILE: src/tdpt_datapath.sv
// Datapath: candidate, odd divisor and a bit-serial restoring divider.
// Depends on tdpt_pkg.
module tdpt_datapath
    import tdpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tdpt_cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0] candidate,
    output tdpt_status_t           status
);

    logic [VALUE_WIDTH-1:0] n_reg;
    logic [VALUE_WIDTH-1:0] d_reg;
    logic [VALUE_WIDTH-1:0] q_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [VALUE_WIDTH:0]   trial;
    logic                   fits;

    assign trial = {rem_reg, q_reg[VALUE_WIDTH-1]} - {1'b0, d_reg};
    assign fits  = ~trial[VALUE_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= candidate;
            d_reg <= VALUE_WIDTH'(3);
        end
        else if (cmd.next_div)
        begin
            d_reg <= d_reg + VALUE_WIDTH'(2);
        end

        if (cmd.div_start)
        begin
            q_reg   <= n_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg <= {q_reg[VALUE_WIDTH-2:0], fits};
            if (fits)
            begin
                rem_reg <= trial[VALUE_WIDTH-1:0];
            end
            else
            begin
                rem_reg <= {rem_reg[VALUE_WIDTH-2:0], q_reg[VALUE_WIDTH-1]};
            end
        end
    end

    always_comb
    begin
        status.below_two = n_reg[VALUE_WIDTH-1] || (n_reg[VALUE_WIDTH-2:1] == '0);
        status.is_two    = (n_reg == VALUE_WIDTH'(2));
        status.is_even   = ~n_reg[0];
        status.div_last  = (cnt_reg == LAST_STEP);
        status.d_gt_q    = (d_reg > q_reg);
        status.rem_zero  = (rem_reg == '0);
    end

endmodule

FILE: src/tdpt_ctrl.sv
// Controller: sequences classification, division passes and result output.
// Depends on tdpt_pkg.
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         is_prime,
    input  tdpt_status_t status,
    output tdpt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   is_prime_reg;
    logic   res_reg;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;
    assign out_free  = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.load = in_valid;
            ST_CHECK:  cmd.div_start = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_EVAL:
            begin
                cmd.next_div  = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_RESULT: ;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            is_prime_reg  <= 1'b0;
            res_reg       <= 1'b0;
        end
        else
        begin
            // in ST_RESULT the output register is handled by that state alone
            if (out_valid_reg && !out_stall && (state_reg != ST_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    priority if (status.below_two)
                    begin
                        res_reg   <= 1'b0;
                        state_reg <= ST_RESULT;
                    end
                    else if (status.is_two)
                    begin
                        res_reg   <= 1'b1;
                        state_reg <= ST_RESULT;
                    end
                    else if (status.is_even)
                    begin
                        res_reg   <= 1'b0;
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (status.div_last)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    // quotient below divisor means d*d > n: no factor left
                    priority if (status.d_gt_q)
                    begin
                        res_reg   <= 1'b1;
                        state_reg <= ST_RESULT;
                    end
                    else if (status.rem_zero)
                    begin
                        res_reg   <= 1'b0;
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        is_prime_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/trial_division_prime_test_top.sv
// Trial-division primality test: one signed candidate in, one flag out.
// Input channel in_valid/in_stall carries candidate; output channel
// out_valid/out_stall carries is_prime. A transaction completes on a rising
// edge with valid high and stall low.
// Negatives, 0, 1 and even values resolve in the check state, with no
// division. Odd values run one bit-serial division per odd divisor
// d = 3, 5, ... until d exceeds the quotient or a remainder is zero; each
// divisor runs a full pass through the shared restoring divider and is then
// evaluated (up to roughly 23170 divisors for a 31-bit prime at
// VALUE_WIDTH = 32).
// One candidate is processed at a time; in_stall is low only while idle.
// The result sits in an output register, so a new candidate is accepted
// while the previous flag still waits on out_stall; a finished result
// waits in the controller until that register is free.
// Reset (rst_n low, asynchronous) returns to idle and drops out_valid.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_datapath.
module trial_division_prime_test_top
    import tdpt_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] candidate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_prime
);

    tdpt_cmd_t    cmd;
    tdpt_status_t status;

    tdpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .status    (status),
        .cmd       (cmd)
    );

    tdpt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .candidate (VALUE_WIDTH'(unsigned'(candidate))),
        .status    (status)
    );

endmodule
